// ===== src/tba_pkg.sv =====
// Shared types, codes and reset values for the typed bump allocator.
package tba_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 128;

  localparam logic [31:0] RESET_WINDOW_BASE = 32'h3E80_0000;
  localparam logic [20:0] RESET_WINDOW_SIZE = 21'h08_0000;
  localparam logic [7:0]  RESET_MAX_ENTRIES = 8'd100;

  localparam int unsigned TYPE_W   = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned MAX_W    = 8;
  localparam int unsigned OFFSET_W = 22;
  localparam int unsigned ALIGN_W  = 5;
  localparam int unsigned IN_DATA_W = 40;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [1:0] {
    CFG_WINDOW_BASE = 2'd0,
    CFG_WINDOW_SIZE = 2'd1,
    CFG_MAX_ENTRIES = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_NEW     = 2'd0,
    STAT_EXIST   = 2'd1,
    STAT_FAIL    = 2'd2,
    STAT_RESTART = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CALC,
    ST_CHECK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] window_base;
    logic [SIZE_W-1:0] window_size;
    logic [MAX_W-1:0]  max_entries;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_e           status;
  } result_t;

endpackage

// ===== src/tba_ram.sv =====
// Generic single-port-write, registered-read RAM.
module tba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tba_engine.sv =====
// Allocation sequencer: record search, start rounding, window check and table update.
module tba_engine #(
  parameter int unsigned TABLE_DEPTH = tba_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned CMW = (CW > tba_pkg::MAX_W) ? CW : tba_pkg::MAX_W,
  localparam int unsigned EW  = tba_pkg::TYPE_W + tba_pkg::ADDR_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tba_pkg::cfg_t               cfg_i,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic                        req_kind_i,
  input  logic [tba_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [tba_pkg::SIZE_W-1:0]  req_size_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output tba_pkg::result_t            res_o
);

  localparam int unsigned SW = tba_pkg::ADDR_W + 1;

  tba_pkg::state_e state_q, state_d;
  logic [tba_pkg::TYPE_W-1:0]   key_q, key_d;
  logic [tba_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [CW-1:0]                count_q, count_d;
  logic [tba_pkg::OFFSET_W-1:0] offset_q, offset_d;
  logic [CW-1:0]                rd_idx_q, rd_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [SW-1:0]                start_q, start_d;
  logic [SW-1:0]                limit_q, limit_d;
  tba_pkg::result_t             res_q, res_d;

  logic          accept;
  logic          full;
  logic          issue;
  logic          hit;
  logic          fail;
  logic [SW-1:0] sum;
  logic [SW+1:0] start_p2;
  logic [EW-1:0] rdata;
  logic          we;
  logic [tba_pkg::ADDR_W-1:0] fail_addr;

  assign accept = req_valid_i && (state_q == tba_pkg::ST_IDLE);
  assign full = (CMW'(count_q) >= CMW'(cfg_i.max_entries)) ||
                (CMW'(count_q) >= CMW'(TABLE_DEPTH));
  assign issue = (state_q == tba_pkg::ST_SEARCH) && (rd_idx_q < count_q);
  assign hit = cmp_vld_q && (rdata[EW-1 -: tba_pkg::TYPE_W] == key_q);
  assign sum = {1'b0, cfg_i.window_base} + SW'(offset_q);
  assign start_p2 = {2'b00, start_q} + (SW+2)'(2);
  assign fail = start_q[SW-1] || (start_p2 > {2'b00, limit_q});
  assign fail_addr = cfg_i.window_base + tba_pkg::ADDR_W'(cfg_i.window_size);
  assign we = (state_q == tba_pkg::ST_CHECK) && !fail;

  tba_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({key_q, start_q[tba_pkg::ADDR_W-1:0]}),
    .re_i   (issue),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tba_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_kind_i == tba_pkg::KIND_RESTART || full) begin
            state_d = tba_pkg::ST_RESP;
          end else if (count_q == '0) begin
            state_d = tba_pkg::ST_CALC;
          end else begin
            state_d = tba_pkg::ST_SEARCH;
          end
        end
      end
      tba_pkg::ST_SEARCH: begin
        if (hit) begin
          state_d = tba_pkg::ST_RESP;
        end else if (!issue && !cmp_vld_q) begin
          state_d = tba_pkg::ST_CALC;
        end
      end
      tba_pkg::ST_CALC:  state_d = tba_pkg::ST_CHECK;
      tba_pkg::ST_CHECK: state_d = tba_pkg::ST_RESP;
      tba_pkg::ST_RESP: begin
        if (res_ready_i) begin
          state_d = tba_pkg::ST_IDLE;
        end
      end
      default: state_d = tba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    key_d     = key_q;
    size_d    = size_q;
    count_d   = count_q;
    offset_d  = offset_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = 1'b0;
    start_d   = start_q;
    limit_d   = limit_q;
    res_d     = res_q;
    unique case (state_q)
      tba_pkg::ST_IDLE: begin
        if (accept) begin
          key_d    = req_type_i;
          size_d   = req_size_i;
          rd_idx_d = '0;
          if (req_kind_i == tba_pkg::KIND_RESTART) begin
            count_d  = '0;
            offset_d = '0;
            res_d    = '{address: '0, status: tba_pkg::STAT_RESTART};
          end else if (full) begin
            res_d = '{address: fail_addr, status: tba_pkg::STAT_FAIL};
          end
        end
      end
      tba_pkg::ST_SEARCH: begin
        cmp_vld_d = issue;
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (hit) begin
          res_d = '{address: rdata[tba_pkg::ADDR_W-1:0], status: tba_pkg::STAT_EXIST};
        end
      end
      tba_pkg::ST_CALC: begin
        if (offset_q == '0) begin
          start_d = sum;
        end else begin
          start_d = {sum[SW-1:tba_pkg::ALIGN_W] +
                     (SW-tba_pkg::ALIGN_W)'(|sum[tba_pkg::ALIGN_W-1:0]),
                     {tba_pkg::ALIGN_W{1'b0}}};
        end
        limit_d = {1'b0, cfg_i.window_base} + SW'(cfg_i.window_size);
      end
      tba_pkg::ST_CHECK: begin
        if (fail) begin
          res_d = '{address: fail_addr, status: tba_pkg::STAT_FAIL};
        end else begin
          count_d  = count_q + CW'(1);
          offset_d = start_q[tba_pkg::OFFSET_W-1:0] -
                     cfg_i.window_base[tba_pkg::OFFSET_W-1:0] +
                     tba_pkg::OFFSET_W'(size_q);
          res_d    = '{address: start_q[tba_pkg::ADDR_W-1:0], status: tba_pkg::STAT_NEW};
        end
      end
      tba_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tba_pkg::ST_IDLE;
      count_q   <= '0;
      offset_q  <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      offset_q  <= offset_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    size_q  <= size_d;
    start_q <= start_d;
    limit_q <= limit_d;
    res_q   <= res_d;
  end

  assign req_ready_o = (state_q == tba_pkg::ST_IDLE);
  assign res_valid_o = (state_q == tba_pkg::ST_RESP);
  assign res_o       = res_q;

endmodule

// ===== src/typed_bump_allocator.sv =====
// Typed bump allocator top level: configuration registers, engine and output register.
//
// Input stream: one item per request. tuser carries the kind (allocate or restart),
// tdata carries the type key and the byte size. Output stream: one result per request,
// tdata carries the buffer address and tuser the status code.
// Configuration: write window_base, window_size and max_entries through the plain write
// port while no request is in flight; writes to an unused index are dropped.
// Flow: a restart or a table-full request goes straight to the response; any other
// request reads the records one record per cycle from the record RAM, answering on a hit.
// On a miss or an empty table it computes the start, checks the window, adds a record.
// The single read port of that RAM sets the search rate.
// One request is worked on at a time; the next one is taken as soon as the result
// sits in the output register, even while the receiver stalls it.
// A stalled result holds in the output register until taken.
// Reset: the record count and the free offset clear at once, the registers return to
// their defaults; the record RAM is not cleared, only records below the count are
// ever read.
module typed_bump_allocator #(
  parameter int unsigned TABLE_DEPTH = tba_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // type_key[15:0], byte_count[36:16], zero pad
  input  logic        s_axis_tuser,  // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // address[31:0]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  tba_pkg::cfg_t    cfg_q, cfg_d;
  tba_pkg::result_t res;
  tba_pkg::result_t out_q;
  logic             out_valid_q;
  logic             res_valid;
  logic             res_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tba_pkg::CFG_WINDOW_BASE: cfg_d.window_base = cfg_data_i;
        tba_pkg::CFG_WINDOW_SIZE: cfg_d.window_size = cfg_data_i[tba_pkg::SIZE_W-1:0];
        tba_pkg::CFG_MAX_ENTRIES: cfg_d.max_entries = cfg_data_i[tba_pkg::MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_base <= tba_pkg::RESET_WINDOW_BASE;
      cfg_q.window_size <= tba_pkg::RESET_WINDOW_SIZE;
      cfg_q.max_entries <= tba_pkg::RESET_MAX_ENTRIES;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tba_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_kind_i (s_axis_tuser),
    .req_type_i (s_axis_tdata[15:0]),
    .req_size_i (s_axis_tdata[36:16]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.address;
  assign m_axis_tuser  = out_q.status;

endmodule
